[sv/cfi_pkg.sv]
`default_nettype none

package cfi_pkg;

    localparam int MAX_DELAY_DEF    = 4096;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CHANNEL_WIDTH   = 3;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC       = 14;
    localparam int DELAY_WIDTH     = 13;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODE  = 2'd0;
    localparam cfg_index_t REG_DELAY = 2'd1;
    localparam cfg_index_t REG_GAIN  = 2'd2;

    localparam logic MODE_FIR = 1'b0;
    localparam logic MODE_IIR = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } cfi_state_t;

endpackage

`default_nettype wire

[sv/cfi_ram.sv]
`default_nettype none

module cfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/comb_filter_fir_iir.sv]
`default_nettype none

// channel  direction  handshake                   payload
// in       to block   in_valid / in_stall         channel, sample_in, block_end
// out      from block out_valid / out_stall       channel_out, sample_out, block_end_out
// cfg      to block   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one item per cycle unless in_stall; results pass the compute stage and the output register
// the rate is set by the feedback path: ram read / forward, multiply, add, saturate in one stage
// after reset the delay ram is cleared, all 2**(clog2(MAX_CHANNELS)+clog2(MAX_DELAY)) words
// (32768 at default sizes), while in_stall is high; cfg writes are taken throughout
// an output stall holds one result in the output register and one in the compute stage

module comb_filter_fir_iir #(
    parameter int MAX_DELAY    = cfi_pkg::MAX_DELAY_DEF,
    parameter int MAX_CHANNELS = cfi_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = cfi_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [cfi_pkg::CHANNEL_WIDTH-1:0]     channel,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                                  block_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cfi_pkg::CHANNEL_WIDTH-1:0]     channel_out,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output logic                                  block_end_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cfi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [cfi_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    import cfi_pkg::*;

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW    = $clog2(MAX_DELAY + 1);
    localparam int AW    = CW + PW;
    localparam int DEPTH = 2 ** AW;
    localparam int PW_W  = GAIN_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W = SAMPLE_WIDTH + GAIN_WIDTH + 2;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(64'sd1 <<< (GAIN_FRAC - 1));

    // configuration registers
    logic                         mode_reg;
    logic [DELAY_WIDTH-1:0]       delay_reg;
    logic signed [GAIN_WIDTH-1:0] gain_reg;

    // clear sequencer
    cfi_state_t    state_reg;
    cfi_state_t    state_next;
    logic [AW-1:0] clr_cnt_reg;

    // ring positions
    logic [PW-1:0] ring_pos_reg [MAX_CHANNELS];

    // stage 0
    logic                     accept;
    logic [CHANNEL_WIDTH-1:0] ch_tmp;
    logic [CW-1:0]            ch_mod;
    logic [LW-1:0]            len;
    logic [PW-1:0]            pos_raw;
    logic [PW-1:0]            pos_cur;
    logic [PW:0]              pos_inc;
    logic [PW-1:0]            pos_next;
    logic [AW-1:0]            rd_addr;

    // stage 1
    logic                            s1_valid_reg;
    logic [AW-1:0]                   s1_addr_reg;
    logic signed [SAMPLE_WIDTH-1:0]  s1_x_reg;
    logic [CHANNEL_WIDTH-1:0]        s1_ch_reg;
    logic                            s1_blk_reg;
    logic                            s1_adv;
    logic                            commit;
    logic [SAMPLE_WIDTH-1:0]         ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0]  d_val;
    logic signed [PW_W-1:0]          prod;
    logic signed [ACC_W-1:0]         acc;
    logic signed [ACC_W-1:0]         quot;
    logic signed [SAMPLE_WIDTH-1:0]  y_val;
    logic [SAMPLE_WIDTH-1:0]         store_val;

    // last write, for read-after-write forwarding
    logic                    wb_valid_reg;
    logic [AW-1:0]           wb_addr_reg;
    logic [SAMPLE_WIDTH-1:0] wb_data_reg;

    // ram write port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SAMPLE_WIDTH-1:0] ram_wdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FIR;
            delay_reg <= DELAY_WIDTH'(1);
            gain_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_DELAY: delay_reg <= cfg_data[DELAY_WIDTH-1:0];
                REG_GAIN:  gain_reg  <= signed'(cfg_data[GAIN_WIDTH-1:0]);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:  state_next = ST_RUN;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // stage 0: channel fold, delay clamp, ring position
    always_comb
    begin
        ch_tmp = channel;
        for (int i = 0; i < 2 ** CHANNEL_WIDTH; i++)
        begin
            if (32'(ch_tmp) >= MAX_CHANNELS)
            begin
                ch_tmp = ch_tmp - CHANNEL_WIDTH'(MAX_CHANNELS);
            end
        end
        ch_mod = CW'(ch_tmp);

        if (delay_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(delay_reg) > MAX_DELAY)
        begin
            len = LW'(MAX_DELAY);
        end
        else
        begin
            len = LW'(delay_reg);
        end

        pos_raw  = ring_pos_reg[ch_mod];
        pos_cur  = (32'(pos_raw) >= 32'(len)) ? '0 : pos_raw;
        pos_inc  = {1'b0, pos_cur} + (PW + 1)'(1);
        pos_next = (32'(pos_inc) >= 32'(len)) ? '0 : pos_inc[PW-1:0];
        rd_addr  = {ch_mod, pos_cur};
    end

    assign s1_adv   = !out_valid || !out_stall;
    assign commit   = s1_valid_reg && s1_adv;
    assign in_stall = (state_reg != ST_RUN) || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                ring_pos_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            ring_pos_reg[ch_mod] <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= rd_addr;
            s1_x_reg    <= sample_in;
            s1_ch_reg   <= channel;
            s1_blk_reg  <= block_end;
        end
    end

    // stage 1: forward, multiply, round, saturate
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            d_val = signed'(wb_data_reg);
        end
        else
        begin
            d_val = signed'(ram_rdata);
        end
        prod = gain_reg * d_val;
        acc  = (ACC_W'(s1_x_reg) <<< GAIN_FRAC) + ACC_W'(prod) + ROUND;
        quot = acc >>> GAIN_FRAC;
        if (quot > SAT_HI)
        begin
            y_val = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (quot < SAT_LO)
        begin
            y_val = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_val = quot[SAMPLE_WIDTH-1:0];
        end
        store_val = (mode_reg == MODE_IIR) ? y_val : s1_x_reg;
    end

    assign ram_we    = commit || (state_reg == ST_CLEAR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : s1_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : store_val;

    cfi_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= store_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (commit)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            channel_out   <= s1_ch_reg;
            sample_out    <= y_val;
            block_end_out <= s1_blk_reg;
        end
    end

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s1_valid_reg && !out_valid))
        else $error("item in flight during ram clear");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (state_reg == ST_RUN))
        else $error("ram clear restarted");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("compute stage lost a held item");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result without a source item");

endmodule

`default_nettype wire

[tb/comb_filter_fir_iir_checker.sv]
`default_nettype none

module comb_filter_fir_iir_checker (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic                                          in_stall,
    input  logic [cfi_pkg::CHANNEL_WIDTH-1:0]             channel,
    input  logic signed [cfi_pkg::SAMPLE_WIDTH_DEF-1:0]   sample_in,
    input  logic                                          block_end,
    input  logic                                          out_valid,
    input  logic                                          out_stall,
    input  logic [cfi_pkg::CHANNEL_WIDTH-1:0]             channel_out,
    input  logic signed [cfi_pkg::SAMPLE_WIDTH_DEF-1:0]   sample_out,
    input  logic                                          block_end_out,
    input  logic                                          cfg_valid,
    input  logic                                          cfg_ready,
    input  logic [cfi_pkg::CFG_INDEX_WIDTH-1:0]           cfg_index,
    input  logic [cfi_pkg::CFG_DATA_WIDTH-1:0]            cfg_data,
    output int                                            fail_count,
    output int                                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfi_pkg::*;

    localparam int RING_WORDS = MAX_CHANNELS_DEF * MAX_DELAY_DEF;
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_WIDTH_DEF - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0]           chan;
        logic [SAMPLE_WIDTH_DEF-1:0]        level;
        logic                               last;
    } filtered_t;

    logic                               mode_q;
    logic [DELAY_WIDTH-1:0]             delay_q;
    logic signed [GAIN_WIDTH-1:0]       gain_q;
    logic signed [SAMPLE_WIDTH_DEF-1:0] ring_mem [RING_WORDS];
    int unsigned                        ring_pos [MAX_CHANNELS_DEF];
    filtered_t                          filtered_q [$];

    function automatic filtered_t comb_filter_sample(
        input logic [CHANNEL_WIDTH-1:0]        ch,
        input logic signed [SAMPLE_WIDTH_DEF-1:0] x,
        input logic                            last
    );
        int unsigned                        len;
        int unsigned                        pos;
        int                                 addr;
        logic signed [SAMPLE_WIDTH_DEF-1:0] d;
        longint                             acc;
        longint                             y;
        filtered_t                          res;
        len = delay_q;
        if (len < 1)
            len = 1;
        if (len > MAX_DELAY_DEF)
            len = MAX_DELAY_DEF;
        pos = ring_pos[ch % MAX_CHANNELS_DEF];
        if (pos >= len)
            pos = 0;
        addr = int'(ch % MAX_CHANNELS_DEF) * MAX_DELAY_DEF + int'(pos);
        d = ring_mem[addr];
        acc = (longint'(x) <<< GAIN_FRAC) + longint'(gain_q) * longint'(d)
            + (longint'(1) <<< (GAIN_FRAC - 1));
        y = acc >>> GAIN_FRAC;
        if (y > SAT_HI)
            y = SAT_HI;
        else if (y < SAT_LO)
            y = SAT_LO;
        ring_mem[addr] = (mode_q == MODE_IIR) ? SAMPLE_WIDTH_DEF'(y) : x;
        pos++;
        if (pos >= len)
            pos = 0;
        ring_pos[ch % MAX_CHANNELS_DEF] = pos;
        res.chan = ch;
        res.level = SAMPLE_WIDTH_DEF'(y);
        res.last = last;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            mode_q = MODE_FIR;
            delay_q = 1;
            gain_q = '0;
            foreach (ring_mem[i])
                ring_mem[i] = '0;
            foreach (ring_pos[i])
                ring_pos[i] = 0;
            filtered_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:  mode_q = cfg_data[0];
                    REG_DELAY: delay_q = cfg_data[DELAY_WIDTH-1:0];
                    REG_GAIN:  gain_q = cfg_data[GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                filtered_q.push_back(comb_filter_sample(channel, sample_in, block_end));
            if (out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("output transfer with no sample pending: channel_out %0d",
                           channel_out);
                    fail_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (channel_out !== want.chan)
                    begin
                        $error("channel_out: expected %0d, actual %0d", want.chan, channel_out);
                        fail_count++;
                    end
                    if (sample_out !== want.level)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.level), sample_out);
                        fail_count++;
                    end
                    if (block_end_out !== want.last)
                    begin
                        $error("block_end_out: expected %0d, actual %0d",
                               want.last, block_end_out);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = filtered_q.size();
    end

endmodule

`default_nettype wire

[tb/comb_filter_fir_iir_tb.sv]
`default_nettype none

module comb_filter_fir_iir_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfi_pkg::*;

    localparam cfg_index_t REG_SPARE = 2'd3;
    localparam int RUN_LIMIT = 600000;
    localparam int LONG_HOLD = 300;
    localparam int PHASES    = 10;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic [CHANNEL_WIDTH-1:0]           channel;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sample_in;
    logic                               block_end;
    logic                               out_valid;
    logic                               out_stall;
    logic [CHANNEL_WIDTH-1:0]           channel_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sample_out;
    logic                               block_end_out;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]         cfg_index;
    logic [CFG_DATA_WIDTH-1:0]          cfg_data;
    int                                 fail_count;
    int                                 outstanding;

    bit tx_smooth;
    bit rx_smooth;
    bit hold_req;
    int cycles;

    comb_filter_fir_iir i_dut (.*);

    comb_filter_fir_iir_checker i_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (rx_smooth)
                out_stall <= 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    out_stall <= 1'b0;
                else if (r < 95)
                begin
                    stall_left = $urandom_range(0, 3);
                    out_stall <= 1'b1;
                end
                else
                begin
                    stall_left = $urandom_range(10, 40);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    task automatic offer_sample(input logic [CHANNEL_WIDTH-1:0] ch,
                                input logic [SAMPLE_WIDTH_DEF-1:0] smp,
                                input logic last);
        int gap;
        int r;
        gap = 0;
        if (!tx_smooth)
        begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        sample_in <= smp;
        block_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_filter(input logic m, input logic [DELAY_WIDTH-1:0] dl,
                              input logic [GAIN_WIDTH-1:0] g);
        put_reg(REG_MODE, CFG_DATA_WIDTH'(m));
        put_reg(REG_DELAY, CFG_DATA_WIDTH'(dl));
        put_reg(REG_GAIN, CFG_DATA_WIDTH'(g));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                                 n;
        int                                 r;
        int                                 base;
        int                                 spread;
        logic                               m;
        logic [DELAY_WIDTH-1:0]             dl;
        logic [GAIN_WIDTH-1:0]              g;
        logic [SAMPLE_WIDTH_DEF-1:0]        smp;
        in_valid = 1'b0;
        channel = '0;
        sample_in = '0;
        block_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        tx_smooth = 1'b1;
        rx_smooth = 1'b1;
        hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unity gain feedforward, delay one: positive and negative overflow
        set_filter(MODE_FIR, 13'd1, 16'sh4000);
        offer_sample(3'd0, 16'sh7FFF, 1'b0);
        offer_sample(3'd0, 16'sh7FFF, 1'b1);
        offer_sample(3'd1, 16'sh8000, 1'b0);
        offer_sample(3'd1, 16'sh8000, 1'b0);
        offer_sample(3'd7, 16'sh5555, 1'b1);
        offer_sample(3'd7, 16'shAAAA, 1'b0);
        wait_quiet();

        // write to an unused index, then most negative gain in feedback mode
        put_reg(REG_SPARE, 16'hFFFF);
        set_filter(MODE_IIR, 13'd2, 16'sh8000);
        offer_sample(3'd2, 16'sd1000, 1'b0);
        offer_sample(3'd2, 16'shFFFF, 1'b0);
        offer_sample(3'd2, 16'sd12345, 1'b1);
        offer_sample(3'd2, 16'sh7FFF, 1'b0);
        offer_sample(3'd2, 16'sh8000, 1'b0);
        wait_quiet();

        // zero delay behaves as one, max positive gain
        set_filter(MODE_IIR, 13'd0, 16'sh7FFF);
        offer_sample(3'd3, 16'sd16384, 1'b0);
        offer_sample(3'd3, 16'sd16384, 1'b0);
        offer_sample(3'd3, 16'shFFFB, 1'b1);
        offer_sample(3'd3, 16'sd3, 1'b0);
        wait_quiet();

        // delay above the ring size clamps; smallest gain exercises rounding
        set_filter(MODE_FIR, 13'h1FFF, 16'sh0001);
        offer_sample(3'd4, 16'sh8000, 1'b0);
        offer_sample(3'd4, 16'sd1, 1'b0);
        offer_sample(3'd4, 16'sd0, 1'b1);
        wait_quiet();

        // shorter delay: ring positions past the new length restart
        set_filter(MODE_FIR, 13'd1, 16'shC000);
        offer_sample(3'd4, 16'sd2, 1'b0);
        offer_sample(3'd4, 16'sd7, 1'b0);
        offer_sample(3'd0, 16'sh8001, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            tx_smooth = (ph == 0) || (ph == 4);
            rx_smooth = (ph == 0);
            m = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r < 6)
                dl = DELAY_WIDTH'($urandom_range(1, 12));
            else if (r == 6)
                dl = '0;
            else if (r == 7)
                dl = DELAY_WIDTH'(MAX_DELAY_DEF);
            else if (r == 8)
                dl = DELAY_WIDTH'($urandom_range(MAX_DELAY_DEF + 1, 8191));
            else
                dl = DELAY_WIDTH'($urandom_range(13, 300));
            r = $urandom_range(0, 7);
            if (r == 0)
                g = 16'h8000;
            else if (r == 1)
                g = 16'h7FFF;
            else
                g = GAIN_WIDTH'($urandom_range(0, 65535));
            set_filter(m, dl, g);
            if (ph == 4)
                hold_req = 1'b1;
            n = $urandom_range(85, 105);
            spread = $urandom_range(1, MAX_CHANNELS_DEF);
            base = $urandom_range(0, MAX_CHANNELS_DEF - 1);
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    smp = 16'h7FFF;
                else if (r == 1)
                    smp = 16'h8000;
                else if (r == 2)
                    smp = SAMPLE_WIDTH_DEF'($urandom_range(0, 255) - 128);
                else
                    smp = SAMPLE_WIDTH_DEF'($urandom_range(0, 65535));
                offer_sample(CHANNEL_WIDTH'((base + $urandom_range(0, spread - 1))
                                            % MAX_CHANNELS_DEF),
                             smp, ($urandom_range(0, 7) == 0));
            end
        end

        wait_quiet();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[comb_filter_fir_iir.f]
sv/cfi_pkg.sv
sv/cfi_ram.sv
sv/comb_filter_fir_iir.sv
tb/comb_filter_fir_iir_checker.sv
tb/comb_filter_fir_iir_tb.sv
